// File: rtl/core/spt_pkg.sv
// Shared types, widths and codes for the sphere pair time of impact block.
`timescale 1ns / 1ps
package spt_pkg;

	localparam int CW   = 32;            // coordinate width
	localparam int FB   = 16;            // fraction bits
	localparam int TW   = 32;            // impact time width
	localparam int DW   = CW + 1;        // difference and radius sum width
	localparam int MW   = DW + 2;        // multiplier operand width (signed)
	localparam int PW   = 2 * MW;        // multiplier product width
	localparam int AW   = 2 * CW + 4;    // a, b/2, c accumulator width (signed)
	localparam int HW   = AW / 2;        // half of an accumulator word
	localparam int XW   = 2 * AW + 4;    // discriminant width (signed)
	localparam int SQW  = XW / 2;        // square root width
	localparam int RMW  = SQW + 3;       // square root remainder width
	localparam int NW   = SQW + 2;       // numerator width (signed)
	localparam int QW   = NW + FB;       // scaled numerator and quotient width
	localparam int RW   = AW + 1;        // divisor and division remainder width
	localparam int CNTW = $clog2(2 * QW + 1);

	localparam int MAC_STEPS  = 20;      // ten products, issue and accumulate
	localparam int WIDE_STEPS = 14;      // seven partial products
	localparam int ROOT_STEPS = SQW;
	localparam int DIV_STEPS  = QW;

	typedef struct packed {
		logic                 second_of_pair;
		logic                 active;
		logic signed [CW-1:0] pos_x;
		logic signed [CW-1:0] pos_y;
		logic signed [CW-1:0] pos_z;
		logic signed [CW-1:0] vel_x;
		logic signed [CW-1:0] vel_y;
		logic signed [CW-1:0] vel_z;
		logic        [CW-1:0] radius;
	} item_t;

	typedef struct packed {
		logic          hit;
		logic [TW-1:0] impact_time;
	} result_t;

	typedef struct packed {
		logic                 live;
		logic signed [DW-1:0] dvx;
		logic signed [DW-1:0] dvy;
		logic signed [DW-1:0] dvz;
		logic signed [DW-1:0] dpx;
		logic signed [DW-1:0] dpy;
		logic signed [DW-1:0] dpz;
		logic        [DW-1:0] rsum;
	} job_t;

	typedef struct packed {
		logic full;
		logic valid;
	} q_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAC,
		ST_PREP,
		ST_WIDE,
		ST_DCHK,
		ST_ROOT,
		ST_NUM,
		ST_DIV,
		ST_DONE
	} back_state_t;

endpackage

// File: rtl/core/spt_front.sv
// Front end: holds the first sphere of a pair and forms relative motion jobs.
`timescale 1ns / 1ps
module spt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  spt_pkg::item_t item,
	input  logic          q_full,
	output logic          full,
	output logic          job_push,
	output spt_pkg::job_t job
);
	import spt_pkg::*;

	logic signed [CW-1:0] hpos_q [3];
	logic signed [CW-1:0] hvel_q [3];
	logic        [CW-1:0] hrad_q;
	logic                 hact_q;
	logic                 take;

	assign full     = q_full;
	assign take     = push && !q_full;
	assign job_push = take && item.second_of_pair;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				hpos_q[i] <= '0;
				hvel_q[i] <= '0;
			end
			hrad_q <= '0;
			hact_q <= 1'b0;
		end else if (take && !item.second_of_pair) begin
			hpos_q[0] <= item.pos_x;
			hpos_q[1] <= item.pos_y;
			hpos_q[2] <= item.pos_z;
			hvel_q[0] <= item.vel_x;
			hvel_q[1] <= item.vel_y;
			hvel_q[2] <= item.vel_z;
			hrad_q    <= item.radius;
			hact_q    <= item.active;
		end
	end

	always_comb begin
		job.live = item.active && hact_q;
		job.dvx  = {item.vel_x[CW-1], item.vel_x} - {hvel_q[0][CW-1], hvel_q[0]};
		job.dvy  = {item.vel_y[CW-1], item.vel_y} - {hvel_q[1][CW-1], hvel_q[1]};
		job.dvz  = {item.vel_z[CW-1], item.vel_z} - {hvel_q[2][CW-1], hvel_q[2]};
		job.dpx  = {item.pos_x[CW-1], item.pos_x} - {hpos_q[0][CW-1], hpos_q[0]};
		job.dpy  = {item.pos_y[CW-1], item.pos_y} - {hpos_q[1][CW-1], hpos_q[1]};
		job.dpz  = {item.pos_z[CW-1], item.pos_z} - {hpos_q[2][CW-1], hpos_q[2]};
		job.rsum = {1'b0, item.radius} + {1'b0, hrad_q};
	end

endmodule

// File: rtl/core/spt_jobq.sv
// Two-entry job queue between the front end and the solver.
`timescale 1ns / 1ps
module spt_jobq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  spt_pkg::job_t     wdata,
	input  logic              pop,
	output spt_pkg::job_t     rdata,
	output spt_pkg::q_status_t status
);
	import spt_pkg::*;

	job_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign status.full  = (cnt_q == 2'd2);
	assign status.valid = (cnt_q != 2'd0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && status.valid;
	assign rdata        = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (do_pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= wdata;
	end

endmodule

// File: rtl/core/spt_back.sv
// Solver: shared multiplier sequencer, digit square root and restoring divider.
`timescale 1ns / 1ps
module spt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  spt_pkg::job_t       job_in,
	input  logic                job_valid,
	output logic                job_pop,
	input  logic                pop,
	output logic                empty,
	output spt_pkg::result_t    result
);
	import spt_pkg::*;

	back_state_t          state_q, state_d;
	logic [CNTW-1:0]      step_q;
	logic                 last_step;
	logic [3:0]           op;
	job_t                 job_q;

	logic signed [AW-1:0] acc_a_q, acc_b_q, acc_c_q;
	logic signed [XW-1:0] disc_q;
	logic        [AW-1:0] bmag_q, cmag_q;
	logic                 cneg_q;
	logic signed [AW:0]   b_q;
	logic        [SQW-1:0] root_q;
	logic        [RMW-1:0] rem_q;
	logic        [XW-1:0] dsh_q;
	logic        [QW-1:0] num_q, quo_q;
	logic        [RW-1:0] drem_q, divisor_q;
	result_t              res_q;
	result_t              out_q;
	logic                 out_valid_q;

	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod_q;
	logic        [XW-1:0] term;
	logic        [AW-1:0] babs, cabs;
	logic        [RMW-1:0] rem_n, trial;
	logic        [RW-1:0] dr_n;
	logic signed [NW-1:0] nval;
	logic                 out_free;

	assign empty    = !out_valid_q;
	assign result   = out_q;
	assign op       = step_q[4:1];
	assign out_free = !out_valid_q || pop;

	function automatic logic signed [MW-1:0] sx(input logic signed [DW-1:0] v);
		sx = {{(MW-DW){v[DW-1]}}, v};
	endfunction

	function automatic logic signed [MW-1:0] zx(input logic [HW-1:0] v);
		zx = {{(MW-HW){1'b0}}, v};
	endfunction

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_MAC) begin
			unique case (op)
				4'd0: begin mul_a = sx(job_q.dvx); mul_b = sx(job_q.dvx); end
				4'd1: begin mul_a = sx(job_q.dvy); mul_b = sx(job_q.dvy); end
				4'd2: begin mul_a = sx(job_q.dvz); mul_b = sx(job_q.dvz); end
				4'd3: begin mul_a = sx(job_q.dvx); mul_b = sx(job_q.dpx); end
				4'd4: begin mul_a = sx(job_q.dvy); mul_b = sx(job_q.dpy); end
				4'd5: begin mul_a = sx(job_q.dvz); mul_b = sx(job_q.dpz); end
				4'd6: begin mul_a = sx(job_q.dpx); mul_b = sx(job_q.dpx); end
				4'd7: begin mul_a = sx(job_q.dpy); mul_b = sx(job_q.dpy); end
				4'd8: begin mul_a = sx(job_q.dpz); mul_b = sx(job_q.dpz); end
				4'd9: begin
					mul_a = {{(MW-DW){1'b0}}, job_q.rsum};
					mul_b = {{(MW-DW){1'b0}}, job_q.rsum};
				end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end else if (state_q == ST_WIDE) begin
			unique case (op)
				4'd0: begin mul_a = zx(bmag_q[HW-1:0]); mul_b = zx(bmag_q[HW-1:0]); end
				4'd1: begin mul_a = zx(bmag_q[HW-1:0]); mul_b = zx(bmag_q[AW-1:HW]); end
				4'd2: begin mul_a = zx(bmag_q[AW-1:HW]); mul_b = zx(bmag_q[AW-1:HW]); end
				4'd3: begin mul_a = zx(acc_a_q[HW-1:0]); mul_b = zx(cmag_q[HW-1:0]); end
				4'd4: begin mul_a = zx(acc_a_q[HW-1:0]); mul_b = zx(cmag_q[AW-1:HW]); end
				4'd5: begin mul_a = zx(acc_a_q[AW-1:HW]); mul_b = zx(cmag_q[HW-1:0]); end
				4'd6: begin mul_a = zx(acc_a_q[AW-1:HW]); mul_b = zx(cmag_q[AW-1:HW]); end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end
	end

	// shift a partial product into place in the discriminant
	always_comb begin
		term = {{(XW-PW){1'b0}}, prod_q};
		unique case (op)
			4'd0:    term = term;
			4'd1:    term = term << (HW + 1);
			4'd2:    term = term << (2 * HW);
			4'd3:    term = term << 2;
			4'd4:    term = term << (HW + 2);
			4'd5:    term = term << (HW + 2);
			4'd6:    term = term << (2 * HW + 2);
			default: term = term;
		endcase
	end

	always_comb begin
		babs  = acc_b_q[AW-1] ? AW'(-acc_b_q) : acc_b_q;
		cabs  = acc_c_q[AW-1] ? AW'(-acc_c_q) : acc_c_q;
		rem_n = {rem_q[RMW-3:0], dsh_q[XW-1:XW-2]};
		trial = {1'b0, root_q, 2'b01};
		dr_n  = {drem_q[RW-2:0], num_q[QW-1]};
		nval  = -{{(NW-AW-1){b_q[AW]}}, b_q} - {2'b00, root_q};
	end

	always_comb begin
		unique case (state_q)
			ST_MAC:  last_step = (step_q == CNTW'(MAC_STEPS - 1));
			ST_WIDE: last_step = (step_q == CNTW'(WIDE_STEPS - 1));
			ST_ROOT: last_step = (step_q == CNTW'(ROOT_STEPS - 1));
			ST_DIV:  last_step = (step_q == CNTW'(DIV_STEPS - 1));
			default: last_step = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = job_in.live ? ST_MAC : ST_DONE;
				end
			end
			ST_MAC:  if (last_step) state_d = ST_PREP;
			ST_PREP: state_d = (acc_a_q == '0) ? ST_DONE : ST_WIDE;
			ST_WIDE: if (last_step) state_d = ST_DCHK;
			ST_DCHK: state_d = disc_q[XW-1] ? ST_DONE : ST_ROOT;
			ST_ROOT: if (last_step) state_d = ST_NUM;
			ST_NUM:  state_d = nval[NW-1] ? ST_DONE : ST_DIV;
			ST_DIV:  if (last_step) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q)
				step_q <= '0;
			else
				step_q <= step_q + 1'b1;
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				job_q   <= job_in;
				acc_a_q <= '0;
				acc_b_q <= '0;
				acc_c_q <= '0;
				res_q   <= '0;
			end
			ST_MAC: begin
				// odd steps take the registered product of the step before
				if (step_q[0]) begin
					if (op < 4'd3)
						acc_a_q <= acc_a_q + prod_q[AW-1:0];
					else if (op < 4'd6)
						acc_b_q <= acc_b_q + prod_q[AW-1:0];
					else if (op < 4'd9)
						acc_c_q <= acc_c_q + prod_q[AW-1:0];
					else
						acc_c_q <= acc_c_q - prod_q[AW-1:0];
				end
			end
			ST_PREP: begin
				b_q       <= {acc_b_q, 1'b0};
				bmag_q    <= {babs[AW-2:0], 1'b0};
				cmag_q    <= cabs;
				cneg_q    <= acc_c_q[AW-1];
				disc_q    <= '0;
				divisor_q <= {acc_a_q, 1'b0};
			end
			ST_WIDE: begin
				if (step_q[0]) begin
					if (op < 4'd3 || cneg_q)
						disc_q <= disc_q + term;
					else
						disc_q <= disc_q - term;
				end
			end
			ST_DCHK: begin
				dsh_q  <= disc_q;
				root_q <= '0;
				rem_q  <= '0;
			end
			ST_ROOT: begin
				dsh_q <= dsh_q << 2;
				if (rem_n >= trial) begin
					rem_q  <= rem_n - trial;
					root_q <= {root_q[SQW-2:0], 1'b1};
				end else begin
					rem_q  <= rem_n;
					root_q <= {root_q[SQW-2:0], 1'b0};
				end
			end
			ST_NUM: begin
				num_q  <= {nval, {FB{1'b0}}};
				quo_q  <= '0;
				drem_q <= '0;
			end
			ST_DIV: begin
				num_q <= num_q << 1;
				if (dr_n >= divisor_q) begin
					drem_q <= dr_n - divisor_q;
					quo_q  <= {quo_q[QW-2:0], 1'b1};
				end else begin
					drem_q <= dr_n;
					quo_q  <= {quo_q[QW-2:0], 1'b0};
				end
				if (last_step) begin
					res_q.hit <= 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_q.hit         <= res_q.hit;
					out_q.impact_time <= !res_q.hit ? '0 :
						(|quo_q[QW-1:TW]) ? {TW{1'b1}} : quo_q[TW-1:0];
				end
			end
			default: ;
		endcase
	end

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.hit) |-> (out_q.impact_time == '0))
		else $error("miss result carries a nonzero time");

	a_idle_takes_job: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && job_valid) |=> (state_q != ST_IDLE))
		else $error("idle solver left a waiting job");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished result not delivered");

endmodule

// File: rtl/core/sphere_pair_time_of_impact.sv
// Top level of the sphere pair time of impact block.
//
// Input words go in on push/full: a word is taken at a clock edge with push
// high and full low. A word with second_of_pair low loads the held sphere and
// gives no result. A word with second_of_pair high is paired with the held
// sphere and queued for the solver; it gives exactly one result word.
// Results come out on empty/pop: the oldest result is on result while empty is
// low and leaves at an edge with pop high.
// The solver forms a, b and c on the shared multiplier, then the discriminant,
// then takes 70 square root digit steps and 88 restoring divide steps before
// empty goes low. The solver works on one pair at a time. Pairs with an
// inactive sphere, no relative motion, no real root or a root in the past
// finish early.
// A two-entry job queue lets the front take words while the solver is busy;
// full rises when it holds two jobs. If pop stays low the solver finishes the
// next job and waits with it, and full follows once the queue fills.
// Reset clears the held sphere to zero, empties the queue and drops any
// pending result.
`timescale 1ns / 1ps
module sphere_pair_time_of_impact (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  spt_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output spt_pkg::result_t result
);
	import spt_pkg::*;

	job_t      fr_job;
	logic      fr_push;
	job_t      q_job;
	q_status_t q_status;
	logic      bk_pop;

	spt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.q_full   (q_status.full),
		.full     (full),
		.job_push (fr_push),
		.job      (fr_job)
	);

	spt_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_push),
		.wdata  (fr_job),
		.pop    (bk_pop),
		.rdata  (q_job),
		.status (q_status)
	);

	spt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_in    (q_job),
		.job_valid (q_status.valid),
		.job_pop   (bk_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

// File: bench/sphere_pair_time_of_impact_tb.sv
// Self-checking bench for the sphere pair time of impact block.
`timescale 1ns / 1ps
module sphere_pair_time_of_impact_tb;
	import spt_pkg::*;

	localparam int LIMIT = 2000000;

	logic    clk = 0;
	logic    arst_n = 0;
	logic    push = 0;
	logic    pop = 0;
	item_t   item = '0;
	logic    full, empty;
	result_t result;

	item_t   pending_items[$];
	result_t expected_results[$];
	bit      fail = 0;
	bit      stim_done = 0;
	bit      hold_rx = 0;
	int      cycle = 0;

	// full and empty as seen at the last rising edge
	logic    full_q = 0;
	logic    empty_q = 1;

	// held first sphere of the current pair
	logic signed [CW-1:0] hp[3], hv[3];
	logic [CW-1:0]        hr;
	logic                 ha;

	sphere_pair_time_of_impact dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result)
	);

	always #5 clk = ~clk;

	function automatic logic [255:0] isqrt(logic [255:0] x);
		logic [255:0] r, b;
		r = 0;
		b = 256'd1 << 254;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// advance the pairing state; return 1 when a result word is due
	function automatic bit solve_pair(item_t it, output result_t res);
		logic signed [255:0] a, bh, pp, b, c, d, n, dv, dp, rr;
		logic [255:0] q;
		logic signed [CW-1:0] p[3], v[3];
		res = '0;
		p = '{it.pos_x, it.pos_y, it.pos_z};
		v = '{it.vel_x, it.vel_y, it.vel_z};
		if (!it.second_of_pair) begin
			hp = p;
			hv = v;
			hr = it.radius;
			ha = it.active;
			return 0;
		end
		if (!it.active || !ha) return 1;
		a = 0; bh = 0; pp = 0;
		for (int i = 0; i < 3; i++) begin
			dv = 256'(signed'(v[i])) - 256'(signed'(hv[i]));
			dp = 256'(signed'(p[i])) - 256'(signed'(hp[i]));
			a += dv * dv;
			bh += dv * dp;
			pp += dp * dp;
		end
		if (a == 0) return 1;
		rr = 256'(hr) + 256'(it.radius);
		b = 2 * bh;
		c = pp - rr * rr;
		d = b * b - 4 * a * c;
		if (d < 0) return 1;
		n = -b - signed'(isqrt(d));
		if (n < 0) return 1;
		q = (256'(n) << FB) / 256'(2 * a);
		res.hit = 1;
		res.impact_time = (q[255:TW] != 0) ? '1 : q[TW-1:0];
		return 1;
	endfunction

	function automatic logic [CW-1:0] rnd_word(int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			default: return $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
		endcase
	endfunction

	function automatic item_t rnd_item(bit second);
		item_t it;
		int m;
		m = $urandom_range(0, 5);
		if (m > 2) m = 1;
		it.second_of_pair = second;
		it.active = ($urandom_range(0, 9) != 0);
		it.pos_x = rnd_word(m); it.pos_y = rnd_word(m); it.pos_z = rnd_word(m);
		it.vel_x = rnd_word(m); it.vel_y = rnd_word(m); it.vel_z = rnd_word(m);
		it.radius = (m == 0) ? $urandom : $urandom_range(0, 32'h0003_0000);
		return it;
	endfunction

	function automatic item_t mk(bit s, bit act, logic [CW-1:0] px, logic [CW-1:0] vx,
		logic [CW-1:0] r);
		item_t it;
		it = '0;
		it.second_of_pair = s; it.active = act;
		it.pos_x = px; it.vel_x = vx; it.radius = r;
		return it;
	endfunction

	initial begin
		hp = '{0, 0, 0}; hv = '{0, 0, 0}; hr = 0; ha = 0;
		// second word straight after reset pairs with the zero sphere
		pending_items.push_back(mk(1, 1, 32'h0010_0000, 32'hFFFF_0000, 32'h0001_0000));
		// approaching head on, then receding, then no motion
		pending_items.push_back(mk(0, 1, 0, 0, 32'h0001_0000));
		pending_items.push_back(mk(1, 1, 32'h000A_0000, 32'hFFFF_0000, 32'h0001_0000));
		pending_items.push_back(mk(1, 1, 32'h000A_0000, 32'h0001_0000, 32'h0001_0000));
		pending_items.push_back(mk(1, 1, 32'h000A_0000, 0, 32'h0001_0000));
		// already overlapping: earlier root is in the past
		pending_items.push_back(mk(1, 1, 32'h0000_8000, 32'hFFFF_0000, 32'h0001_0000));
		// touching now
		pending_items.push_back(mk(1, 1, 32'h0002_0000, 32'hFFFF_0000, 32'h0001_0000));
		// inactive either side
		pending_items.push_back(mk(1, 0, 32'h000A_0000, 32'hFFFF_0000, 32'h0001_0000));
		pending_items.push_back(mk(0, 0, 0, 0, 32'h0001_0000));
		pending_items.push_back(mk(1, 1, 32'h000A_0000, 32'hFFFF_0000, 32'h0001_0000));
		// extremes: saturating time, huge coordinates and radii
		pending_items.push_back(mk(0, 1, 32'h8000_0000, 0, 32'hFFFF_FFFF));
		pending_items.push_back(mk(1, 1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending_items.push_back(mk(0, 1, 32'h8000_0000, 32'h8000_0000, 0));
		pending_items.push_back(mk(1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
		pending_items.push_back(mk(0, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
		pending_items.push_back(mk(1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
		pending_items.push_back(mk(0, 1, 0, 0, 0));
		pending_items.push_back(mk(1, 1, 32'h7FFF_0000, 32'hFFFF_FFFF, 1));
		for (int i = 0; i < 900; i++) begin
			if ($urandom_range(0, 4) == 0)
				pending_items.push_back(rnd_item($urandom_range(0, 1)));
			else begin
				pending_items.push_back(rnd_item(0));
				pending_items.push_back(rnd_item(1));
				i++;
			end
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// driver
	int gap = 0;
	int sent = 0;
	bit drained_pause = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (push && !full_q) begin
				void'(pending_items.pop_front());
				sent++;
				gap = $urandom_range(0, 11);
				if ($urandom_range(0, 3) == 0) gap = 0;
			end
			if (sent == 400 && !drained_pause && expected_results.size() != 0) begin
				push <= 0;
			end else if (pending_items.size() == 0) begin
				push <= 0;
				stim_done = 1;
			end else if (gap > 0 && !(push && full_q)) begin
				gap--;
				push <= 0;
			end else begin
				if (sent == 400) drained_pause = 1;
				push <= 1;
				item <= pending_items[0];
			end
		end
	end

	always @(posedge clk) begin
		full_q = full;
		if (push && !full) begin
			result_t r;
			if (solve_pair(item, r)) expected_results.push_back(r);
		end
	end

	// long receiver hold-off in its own process
	initial begin
		wait (arst_n);
		repeat (3000) @(posedge clk);
		hold_rx = 1;
		repeat (2500) @(posedge clk);
		hold_rx = 0;
	end

	// monitor
	int wait_rx = 0;
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				$error("result word with nothing expected: hit=%0d time=%h",
					result.hit, result.impact_time);
				fail = 1;
			end else begin
				result_t e;
				e = expected_results.pop_front();
				if (result.hit !== e.hit) begin
					$error("hit expected %0d actual %0d", e.hit, result.hit);
					fail = 1;
				end
				if (result.impact_time !== e.impact_time) begin
					$error("impact_time expected %h actual %h",
						e.impact_time, result.impact_time);
					fail = 1;
				end
			end
			wait_rx = $urandom_range(0, 11);
			if ($urandom_range(0, 3) == 0) wait_rx = 0;
		end
	end

	always @(negedge clk) begin
		if (!arst_n || hold_rx) begin
			pop <= 0;
		end else if (pop && !empty_q) begin
			pop <= (wait_rx == 0);
		end else if (wait_rx > 0) begin
			wait_rx--;
			pop <= 0;
		end else begin
			pop <= 1;
		end
	end

	always @(posedge clk) empty_q <= empty;

	// end of run
	initial begin
		wait (arst_n);
		while (!(stim_done && expected_results.size() == 0) && cycle < LIMIT) begin
			@(posedge clk);
			cycle++;
		end
		if (cycle < LIMIT) repeat (400) @(posedge clk);
		if (cycle >= LIMIT) begin
			$display("simulation failed");
		end else if (!fail && expected_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
